>>> rtl/rbi_pkg.sv
// rigid body integrator package: action codes, register indexes, widths
// and the shared fixed-point saturation helper; no dependencies
package rbi_pkg;

   localparam int FracBitsDefault = 16;

   localparam logic [2:0] ACT_FORCE      = 3'd0;
   localparam logic [2:0] ACT_FORCE_AT   = 3'd1;
   localparam logic [2:0] ACT_IMPULSE    = 3'd2;
   localparam logic [2:0] ACT_IMPULSE_AT = 3'd3;
   localparam logic [2:0] ACT_TORQUE     = 3'd4;
   localparam logic [2:0] ACT_TICK       = 3'd5;

   localparam logic [2:0] REG_STATIC     = 3'd0;
   localparam logic [2:0] REG_INV_MASS   = 3'd1;
   localparam logic [2:0] REG_INV_INERT  = 3'd2;
   localparam logic [2:0] REG_SPEED_LIM  = 3'd3;
   localparam logic [2:0] REG_SPIN_LIM   = 3'd4;
   localparam logic [2:0] REG_TIME_LIM   = 3'd5;

   // multiplier operand selects
   localparam logic [3:0] OP_NONE  = 4'd0;
   localparam logic [3:0] OP_FX    = 4'd1;
   localparam logic [3:0] OP_FY    = 4'd2;
   localparam logic [3:0] OP_TQ    = 4'd3;
   localparam logic [3:0] OP_VX    = 4'd4;
   localparam logic [3:0] OP_VY    = 4'd5;
   localparam logic [3:0] OP_W     = 4'd6;
   localparam logic [3:0] OP_IFX   = 4'd7;
   localparam logic [3:0] OP_IFY   = 4'd8;
   localparam logic [3:0] OP_RXFY  = 4'd9;
   localparam logic [3:0] OP_RYFX  = 4'd10;
   localparam logic [3:0] OP_CRI   = 4'd11;
   localparam logic [3:0] OP_SPD   = 4'd12;
   localparam logic [3:0] OP_LIM   = 4'd13;

   typedef struct packed {
      logic [3:0] op;
      logic       start;
      logic       load;
      logic       finish;
   } rbi_cmd_type;

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      if (v > 34'sd2147483647) return 32'sh7fffffff;
      if (v < -34'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

endpackage

>>> rtl/rbi_ctrl.sv
// rigid body integrator controller: sequences the shared multiplier
// depends on rbi_pkg
module rbi_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_go,
   input  logic [2:0]         req_act,
   input  logic               skip,
   output rbi_pkg::rbi_cmd_type cmd,
   output logic               busy
);
   import rbi_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RUN  = 2'd1;

   logic [1:0] state_ff, state_in;
   logic [3:0] step_ff, step_in;
   logic [2:0] act_ff, act_in;
   logic [3:0] last;

   always_comb begin
      unique case (act_ff)
         ACT_FORCE_AT:   last = 4'd3;
         ACT_IMPULSE:    last = 4'd2;
         ACT_IMPULSE_AT: last = 4'd6;
         ACT_TICK:       last = 4'd12;
         default:        last = 4'd0;
      endcase
   end

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      step_in = step_ff;
      act_in = act_ff;
      busy = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_go) begin
               cmd.load = 1'b1;
               act_in = req_act;
               step_in = '0;
               state_in = S_RUN;
            end
         end
         default: begin
            if (skip || step_ff >= last) begin
               cmd.finish = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.start = 1'b1;
               step_in = step_ff + 4'd1;
               unique case (act_ff)
                  ACT_FORCE_AT: begin
                     unique case (step_ff)
                        4'd0: cmd.op = OP_RXFY;
                        4'd1: cmd.op = OP_RYFX;
                        default: cmd.op = OP_NONE;
                     endcase
                  end
                  ACT_IMPULSE:    cmd.op = (step_ff == 4'd0) ? OP_IFX : OP_IFY;
                  ACT_IMPULSE_AT: begin
                     unique case (step_ff)
                        4'd0: cmd.op = OP_IFX;
                        4'd1: cmd.op = OP_IFY;
                        4'd2: cmd.op = OP_RXFY;
                        4'd3: cmd.op = OP_RYFX;
                        4'd4: cmd.op = OP_NONE;
                        default: cmd.op = OP_CRI;
                     endcase
                  end
                  default: begin
                     unique case (step_ff)
                        4'd0: cmd.op = OP_FX;
                        4'd1: cmd.op = OP_FY;
                        4'd2: cmd.op = OP_TQ;
                        4'd3: cmd.op = OP_IFX;
                        4'd4: cmd.op = OP_IFY;
                        4'd5: cmd.op = OP_W;
                        4'd6: cmd.op = OP_VX;
                        4'd7: cmd.op = OP_VY;
                        4'd8: cmd.op = OP_CRI;
                        4'd9: cmd.op = OP_SPD;
                        4'd10: cmd.op = OP_RXFY;
                        default: cmd.op = OP_LIM;
                     endcase
                  end
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff <= '0;
         act_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         act_ff <= act_in;
      end
   end
endmodule

>>> rtl/rbi_dp.sv
// rigid body integrator datapath: state, registers, one shared multiplier
// depends on rbi_pkg
module rbi_dp #(
   parameter int FRAC_BITS = rbi_pkg::FracBitsDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rbi_pkg::rbi_cmd_type cmd,
   output logic                 skip,
   input  logic [2:0]           act,
   input  logic signed [31:0]   fx_i,
   input  logic signed [31:0]   fy_i,
   input  logic signed [31:0]   px_i,
   input  logic signed [31:0]   py_i,
   input  logic signed [31:0]   tq_i,
   input  logic [19:0]          dt_i,
   input  logic                 csr_we,
   input  logic [2:0]           csr_idx,
   input  logic [31:0]          csr_val,
   output logic [192:0]         result
);
   import rbi_pkg::*;

   localparam logic [30:0] ONE_Q  = 31'(64'd65536 << FRAC_BITS >> 16);
   localparam logic [30:0] SLOW_Q = 31'(64'd3277 << FRAC_BITS >> 16);
   localparam logic [30:0] HALF_Q = 31'(64'd32768 << FRAC_BITS >> 16);

   logic        stat_ff;
   logic [30:0] imass_ff, iinert_ff, slim_ff, wlim_ff, tlim_ff;
   logic signed [31:0] px_ff, py_ff, rot_ff, vx_ff, vy_ff, w_ff;
   logic signed [31:0] fsx_ff, fsy_ff, tsum_ff;
   logic        sleep_ff;
   logic [31:0] slow_ff;
   logic [2:0]  act_ff;
   logic signed [31:0] ix_ff, iy_ff, ipx_ff, ipy_ff, itq_ff;
   logic [19:0] dt_ff;
   logic signed [31:0] t0_ff, t1_ff, t2_ff, t3_ff;
   logic [3:0]  pop_ff;
   logic        pvalid_ff;
   logic signed [65:0] prod_ff;
   logic [63:0] spd_ff;

   logic signed [32:0] ma, mb;
   logic signed [65:0] prod;
   logic signed [31:0] q;
   logic signed [31:0] rx, ry;

   assign rx = sat32(34'(ipx_ff) - 34'(px_ff));
   assign ry = sat32(34'(ipy_ff) - 34'(py_ff));

   always_comb begin
      ma = '0;
      mb = '0;
      unique case (cmd.op)
         OP_FX:   begin ma = 33'(fsx_ff);  mb = {2'b0, imass_ff}; end
         OP_FY:   begin ma = 33'(fsy_ff);  mb = {2'b0, imass_ff}; end
         OP_TQ:   begin ma = 33'(tsum_ff); mb = {2'b0, iinert_ff}; end
         OP_IFX:  begin
            ma = (act_ff == ACT_TICK) ? 33'(t0_ff) : 33'(ix_ff);
            mb = (act_ff == ACT_TICK) ? {13'b0, dt_ff} : {2'b0, imass_ff};
         end
         OP_IFY:  begin
            ma = (act_ff == ACT_TICK) ? 33'(t1_ff) : 33'(iy_ff);
            mb = (act_ff == ACT_TICK) ? {13'b0, dt_ff} : {2'b0, imass_ff};
         end
         OP_W:    begin ma = 33'(t2_ff); mb = {13'b0, dt_ff}; end
         OP_VX:   begin ma = 33'(vx_ff); mb = {13'b0, dt_ff}; end
         OP_VY:   begin ma = 33'(vy_ff); mb = {13'b0, dt_ff}; end
         OP_CRI:  begin
            ma = (act_ff == ACT_TICK) ? 33'(w_ff) : 33'(t2_ff);
            mb = (act_ff == ACT_TICK) ? {13'b0, dt_ff} : {2'b0, iinert_ff};
         end
         OP_SPD:  begin ma = 33'(vx_ff); mb = 33'(vx_ff); end
         OP_RXFY: begin
            ma = (act_ff == ACT_TICK) ? 33'(vy_ff) : 33'(rx);
            mb = (act_ff == ACT_TICK) ? 33'(vy_ff) : 33'(iy_ff);
         end
         OP_RYFX: begin ma = 33'(ry); mb = 33'(ix_ff); end
         OP_LIM:  begin ma = {2'b0, slim_ff}; mb = {2'b0, slim_ff}; end
         default: begin ma = '0; mb = '0; end
      endcase
   end

   assign prod = 66'(ma) * 66'(mb);
   // floor shift then saturate
   always_comb begin
      logic signed [65:0] sh;
      sh = prod_ff >>> FRAC_BITS;
      if (sh > 66'sd2147483647) q = 32'sh7fffffff;
      else if (sh < -66'sd2147483648) q = 32'sh80000000;
      else q = sh[31:0];
   end

   assign skip = (act_ff == ACT_TICK) ? (stat_ff || sleep_ff)
                 : (act_ff > ACT_TORQUE || stat_ff);

   always_ff @(posedge clock) begin
      prod_ff <= prod;
      if (cmd.load) begin
         act_ff <= act;
         ix_ff <= fx_i; iy_ff <= fy_i; ipx_ff <= px_i; ipy_ff <= py_i;
         itq_ff <= tq_i; dt_ff <= dt_i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pvalid_ff <= 1'b0;
         pop_ff <= OP_NONE;
      end else begin
         pvalid_ff <= cmd.start;
         pop_ff <= cmd.op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stat_ff <= 1'b0;
         imass_ff <= ONE_Q; iinert_ff <= ONE_Q;
         slim_ff <= SLOW_Q; wlim_ff <= SLOW_Q; tlim_ff <= HALF_Q;
         px_ff <= '0; py_ff <= '0; rot_ff <= '0;
         vx_ff <= '0; vy_ff <= '0; w_ff <= '0;
         fsx_ff <= '0; fsy_ff <= '0; tsum_ff <= '0;
         sleep_ff <= 1'b0; slow_ff <= '0;
         t0_ff <= '0; t1_ff <= '0; t2_ff <= '0; t3_ff <= '0;
         spd_ff <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_idx)
               REG_STATIC: begin
                  stat_ff <= csr_val[0];
                  if (csr_val[0]) begin
                     vx_ff <= '0; vy_ff <= '0; w_ff <= '0;
                  end
               end
               REG_INV_MASS:  imass_ff <= csr_val[30:0];
               REG_INV_INERT: iinert_ff <= csr_val[30:0];
               REG_SPEED_LIM: slim_ff <= csr_val[30:0];
               REG_SPIN_LIM:  wlim_ff <= csr_val[30:0];
               REG_TIME_LIM:  tlim_ff <= csr_val[30:0];
               default: ;
            endcase
         end
         if (pvalid_ff) begin
            if (act_ff == ACT_TICK) begin
               unique case (pop_ff)
                  OP_FX:  t0_ff <= q;
                  OP_FY:  t1_ff <= q;
                  OP_TQ:  t2_ff <= q;
                  OP_IFX: vx_ff <= sat32(34'(vx_ff) + 34'(q));
                  OP_IFY: vy_ff <= sat32(34'(vy_ff) + 34'(q));
                  OP_W:   w_ff <= sat32(34'(w_ff) + 34'(q));
                  OP_VX:  px_ff <= sat32(34'(px_ff) + 34'(q));
                  OP_VY:  py_ff <= sat32(34'(py_ff) + 34'(q));
                  OP_CRI: rot_ff <= sat32(34'(rot_ff) + 34'(q));
                  OP_SPD: spd_ff <= prod_ff[63:0];
                  OP_RXFY: spd_ff <= spd_ff + prod_ff[63:0];
                  default: ;
               endcase
            end else begin
               unique case (pop_ff)
                  OP_IFX:  vx_ff <= sat32(34'(vx_ff) + 34'(q));
                  OP_IFY:  vy_ff <= sat32(34'(vy_ff) + 34'(q));
                  OP_RXFY: t3_ff <= q;
                  OP_RYFX: t2_ff <= sat32(34'(t3_ff) - 34'(q));
                  OP_CRI:  w_ff <= sat32(34'(w_ff) + 34'(q));
                  default: ;
               endcase
            end
         end
         if (cmd.finish && !skip) begin
            unique case (act_ff)
               ACT_FORCE, ACT_FORCE_AT: begin
                  fsx_ff <= sat32(34'(fsx_ff) + 34'(ix_ff));
                  fsy_ff <= sat32(34'(fsy_ff) + 34'(iy_ff));
                  if (act_ff == ACT_FORCE_AT)
                     tsum_ff <= sat32(34'(tsum_ff) + 34'(t2_ff));
                  sleep_ff <= 1'b0;
               end
               ACT_TORQUE: begin
                  tsum_ff <= sat32(34'(tsum_ff) + 34'(itq_ff));
                  sleep_ff <= 1'b0;
               end
               ACT_TICK: begin
                  fsx_ff <= '0; fsy_ff <= '0; tsum_ff <= '0;
                  if (spd_ff < prod_ff[63:0] &&
                      (w_ff[31] ? 33'(-34'(w_ff)) : 33'(w_ff)) < {2'b0, wlim_ff}) begin
                     if (33'(slow_ff) + 33'(dt_ff) > 33'h0ffffffff) begin
                        slow_ff <= 32'hffffffff;
                     end else begin
                        slow_ff <= slow_ff + 32'(dt_ff);
                     end
                     if (33'(slow_ff) + 33'(dt_ff) >= 33'(tlim_ff)) begin
                        sleep_ff <= 1'b1;
                        vx_ff <= '0; vy_ff <= '0; w_ff <= '0;
                     end
                  end else begin
                     slow_ff <= '0;
                  end
               end
               default: sleep_ff <= 1'b0;
            endcase
         end
      end
   end

   assign result = {sleep_ff, w_ff, vy_ff, vx_ff, rot_ff, py_ff, px_ff};
endmodule

>>> rtl/rigid_body_2d_integrator_top.sv
// Rigid body integrator, one 2D body in signed fixed point. One request
// at a time, stepped by the controller through the single shared 33x33
// multiplier: a tick takes the most steps, then a point impulse, a force
// at a point and an impulse, while a force, a torque, an unknown action, a
// tick on a static or sleeping body and any action on a static body skip
// the multiplier. The response is held in one register; the next request
// is taken no earlier than the cycle in which that response is taken.
// Register writes are taken only while idle.
// depends on rbi_pkg, rbi_ctrl, rbi_dp
module rigid_body_2d_integrator_top #(
   parameter int FRAC_BITS = rbi_pkg::FracBitsDefault
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // action, vector_x, vector_y, point_x, point_y, torque_in, time_step
   input  logic [183:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // pos_x, pos_y, angle, vel_x, vel_y, spin, asleep
   output logic [199:0]  rsp_tdata,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [2:0]    csr_index,
   input  logic [31:0]   csr_data
);
   import rbi_pkg::*;

   rbi_cmd_type cmd;
   logic busy, skip, go, pend_ff;
   logic [192:0] res;
   logic [199:0] out_ff;
   logic         ov_ff;

   assign req_tready = !busy && !pend_ff && (!ov_ff || rsp_tready);
   assign go = req_tvalid && req_tready;
   assign csr_ready = !busy && !pend_ff;

   rbi_ctrl u_ctrl (.clock, .reset, .req_go(go), .req_act(req_tdata[2:0]),
      .skip, .cmd, .busy);

   rbi_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (.clock, .reset, .cmd, .skip,
      .act(req_tdata[2:0]), .fx_i(req_tdata[34:3]), .fy_i(req_tdata[66:35]),
      .px_i(req_tdata[98:67]), .py_i(req_tdata[130:99]),
      .tq_i(req_tdata[162:131]), .dt_i(req_tdata[182:163]),
      .csr_we(csr_valid && csr_ready), .csr_idx(csr_index), .csr_val(csr_data),
      .result(res));

   // finish updates state at that edge; capture in the cycle after
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         pend_ff <= cmd.finish;
         if (pend_ff) ov_ff <= 1'b1;
         else if (rsp_tready) ov_ff <= 1'b0;
      end
      if (pend_ff) out_ff <= {7'b0, res};
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata = out_ff;

   a_one_op: assert property (@(posedge clock) disable iff (reset)
      go |=> busy) else $error("request not started");
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response lost");
   a_fin: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> !busy) else $error("controller stuck");
endmodule
